// ===== src/cdd_pkg.sv =====
// Package for the calendar date decrement block: microcode types, control
// words, status structs, the microcode table and calendar helper functions.
// No dependencies.
`default_nettype none

package cdd_pkg;

  localparam int UPC_W = 5;
  typedef logic [UPC_W-1:0] upc_t;

  localparam logic signed [15:0] YEAR_MIN = 16'sh8000;
  localparam logic [16:0] YEAR_BIAS = 17'd32800;
  localparam logic [15:0] RECIP_400 = 16'd41944;
  localparam logic [16:0] DIV_400 = 17'd400;

  localparam logic [4:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef enum logic [2:0] {
    CMD_DAY = 3'd0,
    CMD_WEEK = 3'd1,
    CMD_MONTH = 3'd2,
    CMD_YEAR = 3'd3,
    CMD_DECADE = 3'd4,
    CMD_CENTURY = 3'd5,
    CMD_MILLENNIUM = 3'd6
  } cmd_e;

  typedef enum logic [3:0] {
    UOP_NOP,
    UOP_LOAD,
    UOP_FIXM,
    UOP_LQ,
    UOP_LR,
    UOP_FIXD,
    UOP_DAY,
    UOP_MONTH,
    UOP_YSUB,
    UOP_YSAT,
    UOP_FEB,
    UOP_WRITE
  } uop_e;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_CNT_ZERO,
    C_CMD_DAY,
    C_CMD_MONTH,
    C_CMD_YEAR,
    C_DAY_CONT,
    C_MON_CONT,
    C_OUT_BUSY
  } cond_e;

  typedef struct packed {
    uop_e  uop;
    cond_e cond;
    upc_t  target;
  } ucw_t;

  typedef struct packed {
    logic cnt_zero;
    logic cmd_day;
    logic cmd_month;
    logic cmd_year;
    logic day_cont;
    logic mon_cont;
  } stat_t;

  typedef struct packed {
    logic signed [15:0] year;
    logic [3:0]         month;
    logic [4:0]         day;
    logic               uf;
  } res_t;

  localparam upc_t A_IDLE  = 5'd0;
  localparam upc_t A_DAY   = 5'd9;
  localparam upc_t A_MONTH = 5'd13;
  localparam upc_t A_YEAR  = 5'd17;
  localparam upc_t A_WRITE = 5'd31;

  function automatic ucw_t ucode_rom(input upc_t a);
    ucw_t w;
    case (a)
      5'd0:  w = '{UOP_LOAD,  C_NO_INPUT,  A_IDLE};
      5'd1:  w = '{UOP_FIXM,  C_NEVER,     A_IDLE};
      5'd2:  w = '{UOP_LQ,    C_NEVER,     A_IDLE};
      5'd3:  w = '{UOP_LR,    C_NEVER,     A_IDLE};
      5'd4:  w = '{UOP_FIXD,  C_CNT_ZERO,  A_WRITE};
      5'd5:  w = '{UOP_NOP,   C_CMD_DAY,   A_DAY};
      5'd6:  w = '{UOP_NOP,   C_CMD_MONTH, A_MONTH};
      5'd7:  w = '{UOP_NOP,   C_CMD_YEAR,  A_YEAR};
      5'd8:  w = '{UOP_NOP,   C_ALWAYS,    A_WRITE};
      5'd9:  w = '{UOP_DAY,   C_DAY_CONT,  A_DAY};
      5'd10: w = '{UOP_NOP,   C_CNT_ZERO,  A_WRITE};
      5'd11: w = '{UOP_LQ,    C_NEVER,     A_IDLE};
      5'd12: w = '{UOP_LR,    C_ALWAYS,    A_DAY};
      5'd13: w = '{UOP_MONTH, C_MON_CONT,  A_MONTH};
      5'd14: w = '{UOP_NOP,   C_CNT_ZERO,  A_WRITE};
      5'd15: w = '{UOP_LQ,    C_NEVER,     A_IDLE};
      5'd16: w = '{UOP_LR,    C_ALWAYS,    A_MONTH};
      5'd17: w = '{UOP_YSUB,  C_NEVER,     A_IDLE};
      5'd18: w = '{UOP_YSAT,  C_NEVER,     A_IDLE};
      5'd19: w = '{UOP_LQ,    C_NEVER,     A_IDLE};
      5'd20: w = '{UOP_LR,    C_NEVER,     A_IDLE};
      5'd21: w = '{UOP_FEB,   C_ALWAYS,    A_WRITE};
      5'd31: w = '{UOP_WRITE, C_OUT_BUSY,  A_WRITE};
      default: w = '{UOP_NOP, C_ALWAYS,    A_IDLE};
    endcase
    return w;
  endfunction

  function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    if (m == 4'd2) begin
      len = leap ? 5'd29 : 5'd28;
    end else if (m >= 4'd1 && m <= 4'd12) begin
      len = MONTH_LEN[m - 4'd1];
    end else begin
      len = 5'd31;
    end
    return len;
  endfunction

endpackage

`default_nettype wire

// ===== src/calendar_date_decrement.sv =====
// Top level of the calendar date decrement block: sequencer, datapath and
// output register with its handshake. Depends on cdd_pkg, cdd_sequencer, cdd_datapath.
//
// Usage: an input transfer (in_valid_i high, in_stall_o low) carries a unit
// command, a count and a Gregorian date; one result transfer follows with
// the date moved back by count units and an underflow flag.
// in_stall_o is low only while the sequencer sits at its idle step, so one
// item is worked on at a time; the next one may enter while the previous
// result still waits in the output register.
// The microcode program loads the transfer and clamps month and day, then
// walks days or months, or subtracts years, as the unit command selects.
// Day and month walks go one calendar step per cycle through the datapath,
// pausing to recompute the leap flag after each year boundary.
// Reset returns the sequencer to idle and empties the output register.
// While out_stall_i is high a held result stays, and the sequencer waits at
// its result step while the output register still holds an unaccepted result.
`default_nettype none

module calendar_date_decrement
  import cdd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [2:0]         cmd_i,
  input  wire logic [14:0]        count_i,
  input  wire logic signed [15:0] in_year_i,
  input  wire logic [3:0]         in_month_i,
  input  wire logic [4:0]         in_day_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [15:0]      out_year_o,
  output logic [3:0]              out_month_o,
  output logic [4:0]              out_day_o,
  output logic                    underflow_o
);

  uop_e  uop;
  stat_t stat;
  res_t  res;
  logic  idle;
  logic  out_free;
  logic  load_out;
  logic  out_valid_q, out_valid_d;
  res_t  out_q;

  assign out_free = !out_valid_q || !out_stall_i;
  assign load_out = (uop == UOP_WRITE) && out_free;
  assign in_stall_o = !idle;

  cdd_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .stat_i     (stat),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .uop_o      (uop),
    .idle_o     (idle)
  );

  cdd_datapath u_dp (
    .clk_i      (clk_i),
    .uop_i      (uop),
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd_i),
    .count_i    (count_i),
    .in_year_i  (in_year_i),
    .in_month_i (in_month_i),
    .in_day_i   (in_day_i),
    .stat_o     (stat),
    .res_o      (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_year_o = out_q.year;
  assign out_month_o = out_q.month;
  assign out_day_o = out_q.day;
  assign underflow_o = out_q.uf;

endmodule

`default_nettype wire

// ===== src/cdd_sequencer.sv =====
// Microcode sequencer: step counter, control word lookup and conditional jumps.
// Depends on cdd_pkg.
`default_nettype none

module cdd_sequencer
  import cdd_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire stat_t stat_i,
  input  wire logic  in_valid_i,
  input  wire logic  out_free_i,
  output uop_e       uop_o,
  output logic       idle_o
);

  upc_t upc_q, upc_d;
  ucw_t ucw;
  logic take;

  assign ucw = ucode_rom(upc_q);
  assign uop_o = ucw.uop;
  assign idle_o = (upc_q == A_IDLE);

  always_comb begin
    case (ucw.cond)
      C_NEVER:     take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_NO_INPUT:  take = !in_valid_i;
      C_CNT_ZERO:  take = stat_i.cnt_zero;
      C_CMD_DAY:   take = stat_i.cmd_day;
      C_CMD_MONTH: take = stat_i.cmd_month;
      C_CMD_YEAR:  take = stat_i.cmd_year;
      C_DAY_CONT:  take = stat_i.day_cont;
      C_MON_CONT:  take = stat_i.mon_cont;
      C_OUT_BUSY:  take = !out_free_i;
      default:     take = 1'b0;
    endcase
    upc_d = take ? ucw.target : upc_q + upc_t'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= A_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q == A_IDLE && !in_valid_i) |=> (upc_q == A_IDLE))
    else $error("sequencer left idle without a transfer");

  a_write_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q == A_WRITE && !out_free_i) |=> (upc_q == A_WRITE))
    else $error("result step left while output busy");

  a_write_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q == A_WRITE && out_free_i) |=> (upc_q == A_IDLE))
    else $error("sequencer did not return to idle after result");

endmodule

`default_nettype wire

// ===== src/cdd_datapath.sv =====
// Date datapath: year, month, day, step count, leap flag and year arithmetic,
// driven one micro-operation per cycle. Depends on cdd_pkg.
`default_nettype none

module cdd_datapath
  import cdd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire uop_e               uop_i,
  input  wire logic               in_valid_i,
  input  wire logic [2:0]         cmd_i,
  input  wire logic [14:0]        count_i,
  input  wire logic signed [15:0] in_year_i,
  input  wire logic [3:0]         in_month_i,
  input  wire logic [4:0]         in_day_i,
  output stat_t                   stat_o,
  output res_t                    res_o
);

  logic signed [15:0] y_q, y_d;
  logic [3:0]         m_q, m_d;
  logic [4:0]         d_q, d_d;
  logic [2:0]         cmd_q, cmd_d;
  logic [17:0]        cnt_q, cnt_d;
  logic               uf_q, uf_d;
  logic               leap_q, leap_d;
  logic [7:0]         q_q, q_d;
  logic signed [26:0] ny_q, ny_d;

  logic [16:0] yy;
  logic [32:0] qprod;
  logic [16:0] rem;
  logic [8:0]  rem9;
  logic [3:0]  mprev;
  logic [4:0]  len_cur, len_prev;
  logic [9:0]  mult;
  logic [24:0] yprod;
  logic        cnt_zero;

  assign yy = {y_q[15], y_q} + YEAR_BIAS;
  assign qprod = yy * RECIP_400;
  assign rem = yy - ({9'd0, q_q} * DIV_400);
  assign rem9 = rem[8:0];
  assign mprev = m_q - 4'd1;
  assign len_cur = days_in(m_q, leap_q);
  assign len_prev = days_in(mprev, leap_q);
  assign cnt_zero = (cnt_q == 18'd0);
  assign yprod = cnt_q[14:0] * mult;

  always_comb begin
    case (cmd_q)
      CMD_YEAR:       mult = 10'd1;
      CMD_DECADE:     mult = 10'd10;
      CMD_CENTURY:    mult = 10'd100;
      CMD_MILLENNIUM: mult = 10'd1000;
      default:        mult = 10'd0;
    endcase
  end

  always_comb begin
    y_d = y_q;
    m_d = m_q;
    d_d = d_q;
    cmd_d = cmd_q;
    cnt_d = cnt_q;
    uf_d = uf_q;
    leap_d = leap_q;
    q_d = q_q;
    ny_d = ny_q;
    case (uop_i)
      UOP_LOAD: begin
        if (in_valid_i) begin
          y_d = in_year_i;
          m_d = in_month_i;
          d_d = in_day_i;
          cmd_d = cmd_i;
          cnt_d = {3'd0, count_i};
          uf_d = 1'b0;
        end
      end
      UOP_FIXM: begin
        if (m_q == 4'd0) begin
          m_d = 4'd1;
        end else if (m_q > 4'd12) begin
          m_d = 4'd12;
        end
        if (cmd_q == CMD_WEEK) begin
          cnt_d = (cnt_q << 3) - cnt_q;
        end
      end
      UOP_LQ: q_d = qprod[31:24];
      UOP_LR: leap_d = (rem9[1:0] == 2'd0) && (rem9 != 9'd100) && (rem9 != 9'd200)
                       && (rem9 != 9'd300);
      UOP_FIXD: begin
        if (d_q == 5'd0) begin
          d_d = 5'd1;
        end else if (d_q > len_cur) begin
          d_d = len_cur;
        end
      end
      UOP_DAY: begin
        if (!cnt_zero) begin
          cnt_d = cnt_q - 18'd1;
          if (d_q > 5'd1) begin
            d_d = d_q - 5'd1;
          end else if (m_q == 4'd1) begin
            if (y_q == YEAR_MIN) begin
              uf_d = 1'b1;
              cnt_d = 18'd0;
            end else begin
              y_d = y_q - 16'sd1;
              m_d = 4'd12;
              d_d = 5'd31;
            end
          end else begin
            m_d = mprev;
            d_d = len_prev;
          end
        end
      end
      UOP_MONTH: begin
        if (!cnt_zero) begin
          cnt_d = cnt_q - 18'd1;
          if (m_q == 4'd1) begin
            if (y_q == YEAR_MIN) begin
              uf_d = 1'b1;
              cnt_d = 18'd0;
              d_d = 5'd1;
            end else begin
              y_d = y_q - 16'sd1;
              m_d = 4'd12;
            end
          end else begin
            m_d = mprev;
            if (d_q > len_prev) begin
              d_d = len_prev;
            end
          end
        end
      end
      UOP_YSUB: ny_d = {{11{y_q[15]}}, y_q} - $signed({2'b00, yprod});
      UOP_YSAT: begin
        if (ny_q < $signed({{11{1'b1}}, YEAR_MIN})) begin
          y_d = YEAR_MIN;
          uf_d = 1'b1;
        end else begin
          y_d = ny_q[15:0];
        end
      end
      UOP_FEB: begin
        if (m_q == 4'd2 && d_q == 5'd29 && !leap_q) begin
          d_d = 5'd28;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    y_q <= y_d;
    m_q <= m_d;
    d_q <= d_d;
    cmd_q <= cmd_d;
    cnt_q <= cnt_d;
    uf_q <= uf_d;
    leap_q <= leap_d;
    q_q <= q_d;
    ny_q <= ny_d;
  end

  assign stat_o.cnt_zero = cnt_zero;
  assign stat_o.cmd_day = (cmd_q == CMD_DAY) || (cmd_q == CMD_WEEK);
  assign stat_o.cmd_month = (cmd_q == CMD_MONTH);
  assign stat_o.cmd_year = cmd_q inside {[CMD_YEAR:CMD_MILLENNIUM]};
  assign stat_o.day_cont = !cnt_zero && !(d_q == 5'd1 && m_q == 4'd1);
  assign stat_o.mon_cont = !cnt_zero && (m_q != 4'd1);

  assign res_o.year = y_q;
  assign res_o.month = m_q;
  assign res_o.day = d_q;
  assign res_o.uf = uf_q;

endmodule

`default_nettype wire

// ===== sim/cdd_date_checker.sv =====
// Checker for the calendar date decrement block: watches both channels,
// predicts each result from the accepted transfer and compares field by field.
// Depends on cdd_pkg for the unit command codes.
module cdd_date_checker
  import cdd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_o,
  input  logic [2:0]         cmd_i,
  input  logic [14:0]        count_i,
  input  logic signed [15:0] in_year_i,
  input  logic [3:0]         in_month_i,
  input  logic [4:0]         in_day_i,
  input  logic               out_valid_o,
  input  logic               out_stall_i,
  input  logic signed [15:0] out_year_o,
  input  logic [3:0]         out_month_o,
  input  logic [4:0]         out_day_o,
  input  logic               underflow_o,
  output int                 fail_count_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int YEAR_FLOOR = -32768;

  typedef struct {
    int year;
    int month;
    int day;
    bit uf;
  } date_t;

  date_t expected_dates[$];

  initial begin
    fail_count_o = 0;
    pending_o = 0;
  end

  function automatic bit leap_year(input int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int month_days(input int m, input int y);
    int len;
    case (m)
      2: len = leap_year(y) ? 29 : 28;
      4, 6, 9, 11: len = 30;
      default: len = 31;
    endcase
    return len;
  endfunction

  function automatic date_t date_minus_units(input logic [2:0] c, input logic [14:0] n,
                                             input logic signed [15:0] yi,
                                             input logic [3:0] mi, input logic [4:0] di);
    date_t r;
    int y;
    int m;
    int d;
    int steps;
    int mult;
    int ny;
    bit uf;
    y = yi;
    m = mi;
    d = di;
    uf = 1'b0;
    if (m < 1) m = 1;
    if (m > 12) m = 12;
    if (d < 1) d = 1;
    if (d > month_days(m, y)) d = month_days(m, y);
    if (n != 0) begin
      case (c)
        CMD_DAY, CMD_WEEK: begin
          steps = (c == CMD_WEEK) ? 7 * int'(n) : int'(n);
          while (steps > 0 && !uf) begin
            if (d > 1) begin
              d--;
            end else if (m > 1) begin
              m--;
              d = month_days(m, y);
            end else if (y == YEAR_FLOOR) begin
              uf = 1'b1;
            end else begin
              y--;
              m = 12;
              d = 31;
            end
            steps--;
          end
        end
        CMD_MONTH: begin
          steps = int'(n);
          while (steps > 0 && !uf) begin
            if (m > 1) begin
              m--;
            end else if (y == YEAR_FLOOR) begin
              uf = 1'b1;
            end else begin
              y--;
              m = 12;
            end
            if (!uf && d > month_days(m, y)) d = month_days(m, y);
            steps--;
          end
        end
        CMD_YEAR, CMD_DECADE, CMD_CENTURY, CMD_MILLENNIUM: begin
          mult = (c == CMD_YEAR) ? 1 : (c == CMD_DECADE) ? 10 :
                 (c == CMD_CENTURY) ? 100 : 1000;
          ny = y - int'(n) * mult;
          if (ny < YEAR_FLOOR) begin
            ny = YEAR_FLOOR;
            uf = 1'b1;
          end
          y = ny;
          if (m == 2 && d == 29 && !leap_year(y)) d = 28;
        end
        default: begin
        end
      endcase
      if (uf && c <= CMD_MONTH) begin
        y = YEAR_FLOOR;
        m = 1;
        d = 1;
      end
    end
    r.year = y;
    r.month = m;
    r.day = d;
    r.uf = uf;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    fail_count_o++;
  endtask

  always @(posedge clk_i) begin : watch
    date_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_dates.size() == 0) begin
          report_mismatch($sformatf("result transfer %0d-%0d-%0d with no date pending",
                                    out_year_o, out_month_o, out_day_o));
        end else begin
          want = expected_dates.pop_front();
          if (int'(out_year_o) != want.year || $isunknown(out_year_o))
            report_mismatch($sformatf("year got %0d want %0d", out_year_o, want.year));
          if (int'(out_month_o) != want.month || $isunknown(out_month_o))
            report_mismatch($sformatf("month got %0d want %0d", out_month_o, want.month));
          if (int'(out_day_o) != want.day || $isunknown(out_day_o))
            report_mismatch($sformatf("day got %0d want %0d", out_day_o, want.day));
          if (underflow_o !== want.uf)
            report_mismatch($sformatf("underflow got %b want %b", underflow_o, want.uf));
        end
      end
      if (in_valid_i && !in_stall_o)
        expected_dates.push_back(date_minus_units(cmd_i, count_i, in_year_i,
                                                  in_month_i, in_day_i));
      pending_o <= expected_dates.size();
    end
  end

endmodule

// ===== sim/testbench.sv =====
// Top of the calendar date decrement testbench: clock, reset, directed and
// random date commands, random output stalls and the verdict.
// Depends on cdd_pkg, calendar_date_decrement and cdd_date_checker.
module testbench
  import cdd_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] CMD_UNKNOWN = 3'd7;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int RANDOM_ITEMS = 400;

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [2:0]         cmd_i = '0;
  logic [14:0]        count_i = '0;
  logic signed [15:0] in_year_i = '0;
  logic [3:0]         in_month_i = 4'd1;
  logic [4:0]         in_day_i = 5'd1;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [15:0] out_year_o;
  logic [3:0]         out_month_o;
  logic [4:0]         out_day_o;
  logic               underflow_o;
  int                 fail_count;
  int                 pending;
  int                 cycle_count = 0;
  bit                 quiet = 1'b0;

  calendar_date_decrement dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .cmd_i, .count_i, .in_year_i,
    .in_month_i, .in_day_i, .out_valid_o, .out_stall_i, .out_year_o,
    .out_month_o, .out_day_o, .underflow_o
  );

  cdd_date_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .cmd_i, .count_i, .in_year_i,
    .in_month_i, .in_day_i, .out_valid_o, .out_stall_i, .out_year_o,
    .out_month_o, .out_day_o, .underflow_o,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_date(input logic [2:0] c, input logic [14:0] n,
                           input logic signed [15:0] y, input logic [3:0] m,
                           input logic [4:0] d);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= c;
    count_i <= n;
    in_year_i <= y;
    in_month_i <= m;
    in_day_i <= d;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin : stall_gen
    int len;
    @(posedge clk_i);
    forever begin
      len = pick_gap();
      if (len > 0) begin
        out_stall_i <= 1'b1;
        repeat (len) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  end

  initial begin : stimulus
    logic [2:0]         c;
    logic [14:0]        n;
    logic signed [15:0] y;
    logic [3:0]         m;
    logic [4:0]         d;
    int                 r;
    int                 k;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_date(CMD_DAY, 15'd0, 16'sd2024, 4'd2, 5'd29);
    send_date(CMD_UNKNOWN, 15'd5, 16'sd1999, 4'd0, 5'd0);
    send_date(CMD_DAY, 15'd1, 16'sd2000, 4'd3, 5'd1);
    send_date(CMD_DAY, 15'd1, 16'sd1900, 4'd3, 5'd1);
    send_date(CMD_DAY, 15'd1, 16'sd2024, 4'd1, 5'd1);
    send_date(CMD_DAY, 15'd2, 16'sd2023, 4'd4, 5'd31);
    send_date(CMD_DAY, 15'd3, -16'sd1, 4'd13, 5'd0);
    send_date(CMD_WEEK, 15'd1, 16'sd2024, 4'd3, 5'd5);
    send_date(CMD_MONTH, 15'd1, 16'sd2024, 4'd3, 5'd31);
    send_date(CMD_MONTH, 15'd3, 16'sd2023, 4'd5, 5'd31);
    send_date(CMD_MONTH, 15'd13, 16'sd10, 4'd15, 5'd31);
    send_date(CMD_YEAR, 15'd1, 16'sd2024, 4'd2, 5'd29);
    send_date(CMD_YEAR, 15'd4, 16'sd2024, 4'd2, 5'd29);
    send_date(CMD_YEAR, 15'd0, 16'sd500, 4'd14, 5'd31);
    send_date(CMD_DECADE, 15'd3, 16'sd2000, 4'd2, 5'd29);
    send_date(CMD_CENTURY, 15'd4, 16'sd2000, 4'd2, 5'd29);
    send_date(CMD_CENTURY, 15'd1, 16'sd32767, 4'd12, 5'd31);
    send_date(CMD_MILLENNIUM, 15'h7fff, 16'sd32767, 4'd2, 5'd29);
    send_date(CMD_YEAR, 15'd1, 16'sh8000, 4'd6, 5'd15);
    send_date(CMD_DAY, 15'd1, 16'sh8000, 4'd1, 5'd1);
    send_date(CMD_MONTH, 15'd1, 16'sh8000, 4'd1, 5'd15);
    send_date(CMD_DAY, 15'h7fff, -16'sd32700, 4'd6, 5'd30);
    send_date(CMD_MONTH, 15'h7fff, 16'sd0, 4'd7, 5'd31);
    send_date(CMD_WEEK, 15'h7fff, 16'sd32767, 4'd12, 5'd31);
    hold_until_drained();

    for (k = 0; k < RANDOM_ITEMS; k++) begin
      quiet = (k >= 250 && k < 300);
      if (k == 200) hold_until_drained();
      r = $urandom_range(0, 99);
      c = (r < 5) ? CMD_UNKNOWN : 3'($urandom_range(0, 6));
      r = $urandom_range(0, 99);
      if (c >= CMD_YEAR) n = (r < 40) ? 15'($urandom) : 15'($urandom_range(0, 40));
      else if (r < 70) n = 15'($urandom_range(0, 40));
      else if (r < 92) n = 15'($urandom_range(41, 400));
      else if (r < 98 || c == CMD_WEEK) n = 15'($urandom_range(401, 3000));
      else n = 15'($urandom);
      r = $urandom_range(0, 99);
      if (r < 35) y = 16'($urandom);
      else if (r < 55) y = 16'(-32768 + int'($urandom_range(0, (r < 45) ? 2 : 120)));
      else if (r < 65) y = 16'(32767 - int'($urandom_range(0, 120)));
      else y = 16'($urandom_range(1590, 2410));
      m = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(1, 12));
      r = $urandom_range(0, 99);
      if (r < 15) d = 5'($urandom);
      else if (r < 45) d = 5'($urandom_range(28, 31));
      else d = 5'($urandom_range(1, 31));
      if ($urandom_range(0, 99) < 8) begin
        m = 4'd2;
        d = 5'd29;
      end
      send_date(c, n, y, m, d);
    end
    quiet = 1'b0;

    hold_until_drained();
    repeat (64) @(posedge clk_i);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
